FILE: rtl/psfp_pkg.sv
// Shared types and constants for the particulate sensor frame parser.
// No dependencies; every other file imports this package.
package psfp_pkg;

  localparam logic [7:0]  START_FIRST    = 8'h42;
  localparam logic [7:0]  START_SECOND   = 8'h4D;
  localparam logic [15:0] FRAME_LEN      = 16'd20;
  localparam int          NUM_WORDS      = 6;
  localparam int          WORD_W         = 16;
  localparam int          POS_W          = 5;
  localparam int          WIDX_W         = 3;

  localparam logic [POS_W-1:0] POS_START_HI = 5'd0;
  localparam logic [POS_W-1:0] POS_START_LO = 5'd1;
  localparam logic [POS_W-1:0] POS_LEN_HI   = 5'd2;
  localparam logic [POS_W-1:0] POS_LEN_LO   = 5'd3;
  localparam logic [POS_W-1:0] POS_WORD_LO  = 5'd4;
  localparam logic [POS_W-1:0] POS_WORD_HI  = 5'd15;
  localparam logic [POS_W-1:0] POS_SUM_END  = 5'd22;
  localparam logic [POS_W-1:0] POS_CHK_HI   = 5'd22;
  localparam logic [POS_W-1:0] POS_LAST     = 5'd23;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_BAD_LEN   = 2'd2,
    ST_BAD_SUM   = 2'd3
  } status_t;

  typedef struct packed {
    status_t                             status;
    logic [NUM_WORDS-1:0][WORD_W-1:0]    words;
  } res_t;

endpackage

FILE: rtl/psfp_if.sv
// Handshake channel interfaces for the frame parser: byte input and result output.
// Depends on psfp_pkg.
interface psfp_in_if import psfp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface psfp_out_if import psfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [WORD_W-1:0] pm1_indoor;
  logic [WORD_W-1:0] pm25_indoor;
  logic [WORD_W-1:0] pm10_indoor;
  logic [WORD_W-1:0] pm1_outdoor;
  logic [WORD_W-1:0] pm25_outdoor;
  logic [WORD_W-1:0] pm10_outdoor;

  modport source (output valid, output status, output pm1_indoor, output pm25_indoor,
                  output pm10_indoor, output pm1_outdoor, output pm25_outdoor,
                  output pm10_outdoor, input ready);
  modport sink   (input valid, input status, input pm1_indoor, input pm25_indoor,
                  input pm10_indoor, input pm1_outdoor, input pm25_outdoor,
                  input pm10_outdoor, output ready);
endinterface

FILE: rtl/psfp_in_stage.sv
// Input register for received bytes.
// Depends on psfp_pkg.
module psfp_in_stage import psfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       take,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (take) valid_nxt = 1'b0;
    if (in_valid && in_ready) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) byte_r <= in_byte;
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

FILE: rtl/psfp_parse.sv
// Frame position tracking, field assembly, checksum and status decision.
// Depends on psfp_pkg.
module psfp_parse import psfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output logic       has_res,
  output res_t       res
);

  logic [POS_W-1:0]                 pos_r, pos_nxt;
  logic [WORD_W-1:0]                sum_r, sum_nxt;
  logic [WORD_W-1:0]                len_r, len_nxt;
  logic [NUM_WORDS-1:0][WORD_W-1:0] words_r, words_nxt;
  logic [7:0]                       chk_hi_r, chk_hi_nxt;
  logic [POS_W-1:0]                 word_off;
  logic [WIDX_W-1:0]                widx;
  logic [7:0]                       want;
  logic [WORD_W-1:0]                check;

  assign word_off = pos_r - POS_WORD_LO;
  assign widx     = word_off[WIDX_W:1];
  assign want     = (pos_r == POS_START_HI) ? START_FIRST : START_SECOND;
  assign check    = {chk_hi_r, rx_byte};

  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    len_nxt    = len_r;
    words_nxt  = words_r;
    chk_hi_nxt = chk_hi_r;
    has_res    = 1'b0;
    res.status = ST_OK;
    res.words  = '0;

    if (pos_r == POS_START_HI || pos_r == POS_START_LO) begin
      if (rx_byte != want) begin
        has_res    = 1'b1;
        res.status = ST_BAD_START;
        pos_nxt    = '0;
        sum_nxt    = '0;
      end else begin
        sum_nxt = sum_r + {8'h00, rx_byte};
        pos_nxt = pos_r + 1'b1;
      end
    end else if (pos_r > POS_LAST) begin
      // unreachable position: fall back to hunting
      pos_nxt = '0;
      sum_nxt = '0;
    end else begin
      if (pos_r < POS_SUM_END) sum_nxt = sum_r + {8'h00, rx_byte};
      pos_nxt = pos_r + 1'b1;

      if (pos_r == POS_LEN_HI) begin
        len_nxt = {rx_byte, 8'h00};
      end else if (pos_r == POS_LEN_LO) begin
        len_nxt = {len_r[15:8], rx_byte};
      end else if (pos_r >= POS_WORD_LO && pos_r <= POS_WORD_HI) begin
        if (pos_r[0]) words_nxt[widx] = {words_r[widx][15:8], rx_byte};
        else          words_nxt[widx] = {rx_byte, 8'h00};
      end else if (pos_r == POS_CHK_HI) begin
        chk_hi_nxt = rx_byte;
      end else if (pos_r == POS_LAST) begin
        has_res = 1'b1;
        if (len_r != FRAME_LEN)  res.status = ST_BAD_LEN;
        else if (check != sum_r) res.status = ST_BAD_SUM;
        else                     res.status = ST_OK;
        if (res.status == ST_OK) res.words = words_r;
        pos_nxt = '0;
        sum_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_r    <= '0;
      len_r    <= '0;
      words_r  <= '0;
      chk_hi_r <= '0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      len_r    <= len_nxt;
      words_r  <= words_nxt;
      chk_hi_r <= chk_hi_nxt;
    end
  end

endmodule

FILE: rtl/psfp_out_stage.sv
// Result register holding one finished frame status until it is taken.
// Depends on psfp_pkg.
module psfp_out_stage import psfp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res,
  output logic free,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic valid_r, valid_nxt;
  res_t res_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) valid_nxt = 1'b0;
    if (load)      valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: rtl/particle_sensor_frame_parser_core.sv
// Particulate sensor frame parser, top level. Takes one received serial byte per item
// and emits one result per 24-byte frame (0x42 0x4D, length, six words, six spare bytes,
// checksum) or per bad start byte. One item per clock cycle when not stalled: a byte
// passes an input register, combinational parsing logic, and a result register. A held
// result does not stop the next bytes unless a second result is due before the first
// is taken.
// Depends on psfp_pkg, psfp_if, psfp_in_stage, psfp_parse and psfp_out_stage.
module particle_sensor_frame_parser_core import psfp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  psfp_in_if.sink        in_chan,
  psfp_out_if.source     out_chan
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_go;
  logic       has_res;
  res_t       res;
  logic       out_free;
  res_t       out_res;

  // advance the held byte unless its result has nowhere to go
  assign s1_go = s1_valid && (!has_res || out_free);

  psfp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_byte    (in_chan.rx_byte),
    .in_ready   (in_chan.ready),
    .take       (s1_go),
    .hold_valid (s1_valid),
    .hold_byte  (s1_byte)
  );

  psfp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_go),
    .rx_byte (s1_byte),
    .has_res (has_res),
    .res     (res)
  );

  psfp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_go && has_res),
    .res       (res),
    .free      (out_free),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.status       = out_res.status;
  assign out_chan.pm1_indoor   = out_res.words[0];
  assign out_chan.pm25_indoor  = out_res.words[1];
  assign out_chan.pm10_indoor  = out_res.words[2];
  assign out_chan.pm1_outdoor  = out_res.words[3];
  assign out_chan.pm25_outdoor = out_res.words[4];
  assign out_chan.pm10_outdoor = out_res.words[5];

endmodule
